// File: hdl/cwt_pkg.sv
// ----------------------------------------------------------------------------
// cwt_pkg
// Shared types and constants for the connection idle timing wheel.
// ----------------------------------------------------------------------------
package cwt_pkg;

  // table sizes
  localparam int unsigned MAX_CONNS = 64;
  localparam int unsigned MAX_SLOTS = 64;
  localparam int unsigned CONN_W    = $clog2(MAX_CONNS);
  localparam int unsigned SLOT_W    = $clog2(MAX_SLOTS);
  // slot count needs one more bit so it can hold MAX_SLOTS itself
  localparam int unsigned NSLOT_W   = SLOT_W + 1;

  // field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned DELTA_W   = 16;
  localparam int unsigned ELAPSED_W = 17;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // reset values of the configuration registers
  localparam logic [NSLOT_W-1:0] WHEEL_SLOTS_RST   = NSLOT_W'(64);
  localparam logic [DELTA_W-1:0] TICK_INTERVAL_RST = DELTA_W'(1000);
  localparam logic [SLOT_W-1:0]  CUR_SLOT_RST      = SLOT_W'(1);
  localparam logic [NSLOT_W-1:0] MIN_SLOTS         = NSLOT_W'(2);

  // request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_TOUCH  = 2'd1,
    OP_REMOVE = 2'd2
  } cwt_op_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHEEL_SLOTS   = 1'b0,
    CFG_TICK_INTERVAL = 1'b1
  } cwt_cfg_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_FLUSH
  } cwt_state_e;

  // one result item
  typedef struct packed {
    logic              close_valid;
    logic [CONN_W-1:0] closed_conn;
    logic              last;
  } cwt_result_t;

endpackage

// File: hdl/cwt_slot_ram.sv
// ----------------------------------------------------------------------------
// cwt_slot_ram
// Slot number of each connection: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cwt_slot_ram
  import cwt_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [CONN_W-1:0] waddr_i,
  input  logic [SLOT_W-1:0] wdata_i,
  input  logic [CONN_W-1:0] raddr_i,
  output logic [SLOT_W-1:0] rdata_o
);

  logic [SLOT_W-1:0] mem_q [MAX_CONNS];
  logic [SLOT_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/cwt_out_reg.sv
// ----------------------------------------------------------------------------
// cwt_out_reg
// Output register for result items with valid/ready handshake.
// ----------------------------------------------------------------------------
module cwt_out_reg
  import cwt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cwt_result_t       data_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              close_valid_o,
  output logic [CONN_W-1:0] closed_conn_o,
  output logic              last_o
);

  logic        valid_q, valid_d;
  cwt_result_t data_q;

  // register can take a new result when empty or being drained
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = push_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign close_valid_o = data_q.close_valid;
  assign closed_conn_o = data_q.closed_conn;
  assign last_o        = data_q.last;

endmodule

// File: hdl/connection_idle_timing_wheel_core.sv
// ----------------------------------------------------------------------------
// connection_idle_timing_wheel_core
// Idle-timeout timing wheel over a table of connection ids.
// ----------------------------------------------------------------------------
// touch, remove and a tick that does not advance: the request is accepted, then
// its one result goes into the output register once that register is free
// a tick that advances the wheel scans every connection id through the shared
// slot compare, reading then comparing each id, and takes no new request until done
// reset clears all membership bits, sets current slot 1 and the accumulator to 0,
// and loads the register defaults; the slot table needs no clearing pass
module connection_idle_timing_wheel_core
  import cwt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // requests
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OP_W-1:0]      opcode_i,
  input  logic [CONN_W-1:0]    conn_id_i,
  input  logic [DELTA_W-1:0]   delta_ms_i,
  // results
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 close_valid_o,
  output logic [CONN_W-1:0]    closed_conn_o,
  output logic                 last_o
);

  cwt_state_e state_q, state_d;

  logic [NSLOT_W-1:0]   wheel_slots_q;
  logic [DELTA_W-1:0]   tick_interval_q;
  logic [SLOT_W-1:0]    cur_slot_q, cur_slot_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [MAX_CONNS-1:0] member_q, member_d;
  logic [CONN_W-1:0]    idx_q, idx_d;
  logic [CONN_W-1:0]    pend_id_q, pend_id_d;
  logic                 pend_vld_q, pend_vld_d;

  logic                 accept;
  logic [NSLOT_W-1:0]   n_slots;
  logic [SLOT_W-1:0]    last_slot;
  logic [SLOT_W-1:0]    target_slot;
  logic [NSLOT_W-1:0]   next_slot;
  logic [ELAPSED_W:0]   elapsed_sum;
  logic [ELAPSED_W-1:0] elapsed_sat;
  logic                 advance;
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_rdata;
  logic                 slot_match;
  logic                 push;
  cwt_result_t          push_data;
  logic                 out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_slots_q   <= WHEEL_SLOTS_RST;
      tick_interval_q <= TICK_INTERVAL_RST;
    end else if (cfg_we_i) begin
      case (cwt_cfg_e'(cfg_addr_i))
        CFG_WHEEL_SLOTS:   wheel_slots_q   <= cfg_data_i[NSLOT_W-1:0];
        CFG_TICK_INTERVAL: tick_interval_q <= cfg_data_i[DELTA_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp slot count into the supported range
  always_comb begin
    if (wheel_slots_q < MIN_SLOTS) begin
      n_slots = MIN_SLOTS;
    end else if (wheel_slots_q > NSLOT_W'(MAX_SLOTS)) begin
      n_slots = NSLOT_W'(MAX_SLOTS);
    end else begin
      n_slots = wheel_slots_q;
    end
  end

  assign last_slot = SLOT_W'(n_slots - NSLOT_W'(1));

  // touch target: slot behind the current one, kept inside the wheel
  always_comb begin
    if (cur_slot_q == '0) begin
      target_slot = last_slot;
    end else if ({1'b0, cur_slot_q - SLOT_W'(1)} >= n_slots) begin
      target_slot = last_slot;
    end else begin
      target_slot = cur_slot_q - SLOT_W'(1);
    end
  end

  // saturating accumulator and advance decision
  assign elapsed_sum = {1'b0, elapsed_q} + (ELAPSED_W+1)'(delta_ms_i);
  assign elapsed_sat = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
  assign advance     = elapsed_sat > ELAPSED_W'(tick_interval_q);
  assign next_slot   = {1'b0, cur_slot_q} + NSLOT_W'(1);

  // slot table
  assign ram_we = accept && (opcode_i == OP_TOUCH);

  cwt_slot_ram u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (conn_id_i),
    .wdata_i (target_slot),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // shared compare during the scan
  assign slot_match = member_q[idx_q] && (ram_rdata == cur_slot_q);

  // sequencer
  always_comb begin
    state_d    = state_q;
    cur_slot_d = cur_slot_q;
    elapsed_d  = elapsed_q;
    member_d   = member_q;
    idx_d      = idx_q;
    pend_id_d  = pend_id_q;
    pend_vld_d = pend_vld_q;
    push       = 1'b0;
    push_data  = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pend_vld_d = 1'b0;
          pend_id_d  = '0;
          state_d    = ST_FLUSH;
          case (cwt_op_e'(opcode_i))
            OP_TICK: begin
              if (advance) begin
                elapsed_d  = '0;
                cur_slot_d = (next_slot >= n_slots) ? '0 : next_slot[SLOT_W-1:0];
                idx_d      = '0;
                state_d    = ST_SCAN_RD;
              end else begin
                elapsed_d = elapsed_sat;
              end
            end
            OP_TOUCH:  member_d[conn_id_i] = 1'b1;
            OP_REMOVE: member_d[conn_id_i] = 1'b0;
            default: ;
          endcase
        end
      end

      // slot of idx_q is read from the table this cycle
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CMP;
      end

      // hold one match back so the final close can carry last
      ST_SCAN_CMP: begin
        if (slot_match && pend_vld_q && !out_free) begin
          state_d = ST_SCAN_CMP;
        end else begin
          if (slot_match) begin
            if (pend_vld_q) begin
              push      = 1'b1;
              push_data = '{close_valid: 1'b1, closed_conn: pend_id_q, last: 1'b0};
            end
            pend_vld_d      = 1'b1;
            pend_id_d       = idx_q;
            member_d[idx_q] = 1'b0;
          end
          idx_d   = idx_q + CONN_W'(1);
          state_d = (idx_q == CONN_W'(MAX_CONNS - 1)) ? ST_FLUSH : ST_SCAN_RD;
        end
      end

      // final result of the request
      ST_FLUSH: begin
        if (out_free) begin
          push      = 1'b1;
          push_data = '{close_valid: pend_vld_q,
                        closed_conn: pend_vld_q ? pend_id_q : '0,
                        last:        1'b1};
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cur_slot_q <= CUR_SLOT_RST;
      elapsed_q  <= '0;
      member_q   <= '0;
      idx_q      <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_slot_q <= cur_slot_d;
      elapsed_q  <= elapsed_d;
      member_q   <= member_d;
      idx_q      <= idx_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  // pending close id
  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
  end

  // result register
  cwt_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .data_i        (push_data),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .close_valid_o (close_valid_o),
    .closed_conn_o (closed_conn_o),
    .last_o        (last_o)
  );

endmodule
